### rtl/core/owts_pkg.sv
// Shared types and constants for the one-wire temperature read sequencer.
package owts_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_RESET_LOW    = 3'd0,
    REG_PRES_TIMEOUT = 3'd1,
    REG_GAP          = 3'd2,
    REG_WRITE_SLOT   = 3'd3,
    REG_SAMPLE_DELAY = 3'd4,
    REG_READ_RECOV   = 3'd5
  } reg_idx_t;

  localparam logic [9:0]  ResetLowDefault    = 10'd642;
  localparam logic [15:0] PresTimeoutDefault = 16'd6000;
  localparam logic [15:0] GapDefault         = 16'd1000;
  localparam logic [6:0]  WriteSlotDefault   = 7'd68;
  localparam logic [3:0]  SampleDelayDefault = 4'd6;
  localparam logic [7:0]  ReadRecovDefault   = 8'd48;

  // ROM command bytes: skip ROM, convert, skip ROM, read scratchpad
  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadPad  = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_PRES_WAIT = 4'd2,
    PH_GAP       = 4'd3,
    PH_WR_LOW    = 4'd4,
    PH_WR_HOLD   = 4'd5,
    PH_WR_REL    = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_REC    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [15:0] presence_timeout_ticks;
    logic [15:0] gap_ticks;
    logic [6:0]  write_slot_ticks;
    logic [3:0]  sample_delay_ticks;
    logic [7:0]  read_recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_missing;
    logic signed [15:0] temperature_raw;
  } result_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CmdSkipRom;
      2'd1:    b = CmdConvert;
      2'd2:    b = CmdSkipRom;
      default: b = CmdReadPad;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/owts_cfg_regs.sv
// APB-style register file holding the bus timing tick counts.
module owts_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owts_pkg::CfgAddrW-1:0] paddr,
  input  logic [owts_pkg::CfgDataW-1:0] pwdata,
  output logic [owts_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output owts_pkg::cfg_t                cfg
);
  import owts_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_RESET_LOW:    cfg_nxt.reset_low_ticks        = pwdata[9:0];
        REG_PRES_TIMEOUT: cfg_nxt.presence_timeout_ticks = pwdata[15:0];
        REG_GAP:          cfg_nxt.gap_ticks              = pwdata[15:0];
        REG_WRITE_SLOT:   cfg_nxt.write_slot_ticks       = pwdata[6:0];
        REG_SAMPLE_DELAY: cfg_nxt.sample_delay_ticks     = pwdata[3:0];
        REG_READ_RECOV:   cfg_nxt.read_recovery_ticks    = pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESET_LOW:    prdata = {22'd0, cfg_r.reset_low_ticks};
      REG_PRES_TIMEOUT: prdata = {16'd0, cfg_r.presence_timeout_ticks};
      REG_GAP:          prdata = {16'd0, cfg_r.gap_ticks};
      REG_WRITE_SLOT:   prdata = {25'd0, cfg_r.write_slot_ticks};
      REG_SAMPLE_DELAY: prdata = {28'd0, cfg_r.sample_delay_ticks};
      REG_READ_RECOV:   prdata = {24'd0, cfg_r.read_recovery_ticks};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks        <= ResetLowDefault;
      cfg_r.presence_timeout_ticks <= PresTimeoutDefault;
      cfg_r.gap_ticks              <= GapDefault;
      cfg_r.write_slot_ticks       <= WriteSlotDefault;
      cfg_r.sample_delay_ticks     <= SampleDelayDefault;
      cfg_r.read_recovery_ticks    <= ReadRecovDefault;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/owts_seq_core.sv
// Sequencer state and per-tick next-state logic.
module owts_seq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              cmd,
  input  logic              line_level,
  input  owts_pkg::cfg_t    cfg,
  output owts_pkg::result_t res
);
  import owts_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [2:0]  cmd_idx_r, cmd_idx_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic        missing_r, missing_nxt;

  logic [15:0] limit;
  logic [16:0] tinc;
  logic        hit;
  logic [4:0]  bc_inc;
  logic [2:0]  ci_inc;
  logic [7:0]  cur_byte;

  // Tick limit for whichever phase is counting
  always_comb begin
    case (phase_r)
      PH_RST_LOW:   limit = {6'd0, cfg.reset_low_ticks};
      PH_PRES_WAIT: limit = cfg.presence_timeout_ticks;
      PH_GAP:       limit = cfg.gap_ticks;
      PH_WR_HOLD:   limit = {9'd0, cfg.write_slot_ticks};
      PH_RD_WAIT:   limit = {12'd0, cfg.sample_delay_ticks};
      PH_RD_REC:    limit = {8'd0, cfg.read_recovery_ticks};
      default:      limit = 16'd0;
    endcase
  end

  assign tinc     = {1'b0, timer_r} + 17'd1;
  assign hit      = tinc >= {1'b0, limit};
  assign bc_inc   = bit_cnt_r + 5'd1;
  assign ci_inc   = cmd_idx_r + 3'd1;
  assign cur_byte = cmd_byte(cmd_idx_r[1:0]);

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd_idx_nxt = cmd_idx_r;
    shift_nxt   = shift_r;
    missing_nxt = missing_r;
    res.drive_low        = 1'b0;
    res.busy_res         = 1'b1;
    res.done_res         = 1'b0;
    res.temperature_raw  = '0;

    case (phase_r)
      PH_RST_LOW: begin
        res.drive_low = 1'b1;
        timer_nxt     = hit ? 16'd0 : tinc[15:0];
        if (hit) phase_nxt = PH_PRES_WAIT;
      end
      PH_PRES_WAIT: begin
        if (!line_level) begin
          timer_nxt = 16'd0;
          phase_nxt = PH_GAP;
        end else begin
          timer_nxt = hit ? 16'd0 : tinc[15:0];
          if (hit) begin
            missing_nxt = 1'b1;
            phase_nxt   = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        timer_nxt = hit ? 16'd0 : tinc[15:0];
        if (hit) begin
          bit_cnt_nxt = 5'd0;
          phase_nxt   = PH_WR_LOW;
        end
      end
      PH_WR_LOW: begin
        res.drive_low = 1'b1;
        timer_nxt     = 16'd0;
        phase_nxt     = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        res.drive_low = ~cur_byte[bit_cnt_r[2:0]];
        timer_nxt     = hit ? 16'd0 : tinc[15:0];
        if (hit) phase_nxt = PH_WR_REL;
      end
      PH_WR_REL: begin
        bit_cnt_nxt = bc_inc;
        phase_nxt   = PH_WR_LOW;
        if (bc_inc >= 5'd8) begin
          bit_cnt_nxt = 5'd0;
          cmd_idx_nxt = ci_inc;
          if (ci_inc == 3'd2) begin
            timer_nxt = 16'd0;
            phase_nxt = PH_RST_LOW;
          end else if (ci_inc >= 3'd4) begin
            shift_nxt = 16'd0;
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        res.drive_low = 1'b1;
        timer_nxt     = 16'd0;
        phase_nxt     = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        timer_nxt = hit ? 16'd0 : tinc[15:0];
        if (hit) begin
          shift_nxt = {line_level, shift_r[15:1]};
          phase_nxt = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        timer_nxt = hit ? 16'd0 : tinc[15:0];
        if (hit) begin
          bit_cnt_nxt = bc_inc;
          if (bc_inc >= 5'd16) begin
            res.done_res        = 1'b1;
            res.temperature_raw = shift_r;
            bit_cnt_nxt         = 5'd0;
            phase_nxt           = PH_IDLE;
          end else begin
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
        if (cmd) begin
          missing_nxt = 1'b0;
          cmd_idx_nxt = 3'd0;
          bit_cnt_nxt = 5'd0;
          timer_nxt   = 16'd0;
          shift_nxt   = 16'd0;
          phase_nxt   = PH_RST_LOW;
        end
      end
    endcase
    res.presence_missing = missing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      bit_cnt_r <= '0;
      cmd_idx_r <= '0;
      shift_r   <= '0;
      missing_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      cmd_idx_r <= cmd_idx_nxt;
      shift_r   <= shift_nxt;
      missing_r <= missing_nxt;
    end
  end

endmodule

### rtl/core/one_wire_temperature_read_sequencer.sv
// Top level of the one-wire temperature read sequencer.
//
// Usage: each input item is one 1 us tick carrying cmd and the sampled bus
// level; each tick yields exactly one result item with the bus drive, busy,
// done, presence-missing flag and, on the done tick, the raw temperature.
// A cmd of 1 on an idle tick starts reset, skip ROM + convert, reset,
// skip ROM + read scratchpad and sixteen read slots.
// Channels: in_* and out_* use valid/stall; an item moves when valid is high
// and stall is low. Timing registers sit behind the APB-style port.
// Path: a result reaches out_* through the input register, then the result
// register. Throughput: one tick per cycle while out_stall is low; the step
// loop over the sequencer state sets that rate.
// Stall: a stalled result holds; the input register keeps taking one more
// tick, then in_stall rises until the result register drains.
// Reset (rst_n low, synchronous): sequencer idle, pipeline empty, timing
// registers back to their defaults.
module one_wire_temperature_read_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic                          in_line_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_drive_low,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_presence_missing,
  output logic signed [15:0]            out_temperature_raw,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owts_pkg::CfgAddrW-1:0] paddr,
  input  logic [owts_pkg::CfgDataW-1:0] pwdata,
  output logic [owts_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import owts_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t res_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_cmd_r, s1_level_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_adv, in_acc;

  owts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Result register can take a new item when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  owts_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .cmd        (s1_cmd_r),
    .line_level (s1_level_r),
    .cfg        (cfg),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_cmd;
      s1_level_r <= in_line_level;
    end
    if (s1_adv) res_r <= step_res;
  end

  assign out_valid            = out_valid_r;
  assign out_drive_low        = res_r.drive_low;
  assign out_busy_res         = res_r.busy_res;
  assign out_done_res         = res_r.done_res;
  assign out_presence_missing = res_r.presence_missing;
  assign out_temperature_raw  = res_r.temperature_raw;

endmodule
